[design/bise_pkg.sv]
package bise_pkg;

  localparam int IDX_W          = 12;
  localparam int CNT_W          = 13;
  localparam int MAX_ITEMS_DEF  = 4096;
  localparam int LIST_DEPTH_DEF = 4096;
  localparam int Q_DEPTH        = 2;
  localparam logic [CNT_W-1:0] ITEM_COUNT_RST = 13'd4096;

  typedef enum logic [2:0] {
    REQ_BEGIN  = 3'd0,
    REQ_LEFT   = 3'd1,
    REQ_RIGHT  = 3'd2,
    REQ_FINISH = 3'd3,
    REQ_PULL   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    OP_UNION = 2'd0,
    OP_INTER = 2'd1,
    OP_DIFF  = 2'd2,
    OP_COMPL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_ELEM = 2'd0,
    ST_END  = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2,
    PH_OUT   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CMD_ERR,
    CMD_BEGIN,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_FINISH,
    CMD_PULL
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    op_e              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLEAR,
    B_ELEM,
    B_DLIST,
    B_DMARK,
    B_CCHK,
    B_RESP
  } back_state_e;

endpackage

[design/bise_ram.sv]
module bise_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[design/bise_front.sv]
module bise_front #(
  parameter int UW = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [2:0]                req_type_i,
  input  logic [1:0]                set_op_i,
  input  logic [bise_pkg::IDX_W-1:0] item_index_i,
  input  logic [UW-1:0]             univ_i,
  output bise_pkg::cmd_t            cmd_o
);

  bise_pkg::phase_e phase_q, phase_d;
  bise_pkg::op_e    op_q, op_d;
  logic             in_range;
  logic             in_build;

  assign in_range = 32'(item_index_i) < 32'(univ_i);
  assign in_build = (phase_q == bise_pkg::PH_LEFT) || (phase_q == bise_pkg::PH_RIGHT);

  // classification
  always_comb begin
    cmd_o.kind = bise_pkg::CMD_ERR;
    cmd_o.op   = bise_pkg::op_e'(set_op_i);
    cmd_o.idx  = item_index_i;
    unique case (req_type_i)
      bise_pkg::REQ_BEGIN: begin
        if (!in_build) cmd_o.kind = bise_pkg::CMD_BEGIN;
      end
      bise_pkg::REQ_LEFT: begin
        if (phase_q == bise_pkg::PH_LEFT && op_q != bise_pkg::OP_COMPL && in_range)
          cmd_o.kind = bise_pkg::CMD_LEFT;
      end
      bise_pkg::REQ_RIGHT: begin
        if (in_build && in_range) cmd_o.kind = bise_pkg::CMD_RIGHT;
      end
      bise_pkg::REQ_FINISH: begin
        if (in_build) cmd_o.kind = bise_pkg::CMD_FINISH;
      end
      bise_pkg::REQ_PULL: begin
        if (phase_q == bise_pkg::PH_OUT) cmd_o.kind = bise_pkg::CMD_PULL;
      end
      default: cmd_o.kind = bise_pkg::CMD_ERR;
    endcase
  end

  // phase tracking
  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    if (accept_i) begin
      unique case (cmd_o.kind)
        bise_pkg::CMD_BEGIN: begin
          phase_d = bise_pkg::PH_LEFT;
          op_d    = bise_pkg::op_e'(set_op_i);
        end
        bise_pkg::CMD_RIGHT:  phase_d = bise_pkg::PH_RIGHT;
        bise_pkg::CMD_FINISH: phase_d = bise_pkg::PH_OUT;
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bise_pkg::PH_IDLE;
      op_q    <= bise_pkg::OP_UNION;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
    end
  end

endmodule

[design/bise_fifo.sv]
module bise_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bise_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output bise_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int PW = $clog2(bise_pkg::Q_DEPTH);
  localparam int CW = $clog2(bise_pkg::Q_DEPTH + 1);

  bise_pkg::cmd_t  mem_q [bise_pkg::Q_DEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(bise_pkg::Q_DEPTH));
  assign head_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(bise_pkg::Q_DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(bise_pkg::Q_DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[design/bise_back.sv]
module bise_back #(
  parameter int MAX_ITEMS  = bise_pkg::MAX_ITEMS_DEF,
  parameter int LIST_DEPTH = bise_pkg::LIST_DEPTH_DEF,
  parameter int UW         = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [UW-1:0]              univ_i,
  input  bise_pkg::cmd_t             head_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       init_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [bise_pkg::IDX_W-1:0] out_index_o,
  output logic [1:0]                 out_status_o
);

  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int LAW = $clog2(LIST_DEPTH);
  localparam int LCW = $clog2(LIST_DEPTH + 1);
  localparam int WPW = (LCW > UW) ? LCW : UW;

  bise_pkg::back_state_e state_q, state_d;
  bise_pkg::op_e         op_q, op_d;
  bise_pkg::cmd_t        cmd_q, cmd_d;
  bise_pkg::status_e     res_st_q, res_st_d;
  logic [AW-1:0]         res_idx_q, res_idx_d;
  logic [AW-1:0]         lv_q, lv_d;
  logic [AW-1:0]         sw_q, sw_d;
  logic [LCW-1:0]        lc_q, lc_d;
  logic [WPW-1:0]        wp_q, wp_d;
  logic                  init_q, init_d;
  logic                  ov_q, ov_d;
  logic [bise_pkg::IDX_W-1:0] oi_q, oi_d;
  logic [1:0]            os_q, os_d;

  logic                  m_we, m_wdata, m_rdata;
  logic [AW-1:0]         m_waddr, m_raddr;
  logic                  l_we;
  logic [LAW-1:0]        l_waddr, l_raddr;
  logic [bise_pkg::IDX_W-1:0] l_wdata, l_rdata;

  logic sweep_last, slot_free, diff_more, comp_more, list_full;

  assign sweep_last = (sw_q == AW'(MAX_ITEMS - 1));
  assign slot_free  = !ov_q || !out_stall_i;
  assign diff_more  = 32'(wp_q) < 32'(lc_q);
  assign comp_more  = 32'(wp_q) < 32'(univ_i);
  assign list_full  = (lc_q == LCW'(LIST_DEPTH));

  assign init_o       = init_q;
  assign out_valid_o  = ov_q;
  assign out_index_o  = oi_q;
  assign out_status_o = os_q;

  bise_ram #(.WIDTH(1), .DEPTH(MAX_ITEMS)) u_mark (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  bise_ram #(.WIDTH(bise_pkg::IDX_W), .DEPTH(LIST_DEPTH)) u_list (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bise_pkg::B_IDLE: begin
        if (!empty_i) begin
          unique case (head_i.kind)
            bise_pkg::CMD_BEGIN: state_d = bise_pkg::B_CLEAR;
            bise_pkg::CMD_FINISH: begin
              if (op_q == bise_pkg::OP_UNION || op_q == bise_pkg::OP_INTER)
                state_d = bise_pkg::B_CLEAR;
            end
            bise_pkg::CMD_LEFT, bise_pkg::CMD_RIGHT: state_d = bise_pkg::B_ELEM;
            bise_pkg::CMD_PULL: begin
              if (op_q == bise_pkg::OP_DIFF && diff_more) state_d = bise_pkg::B_DLIST;
              else if (op_q == bise_pkg::OP_COMPL && comp_more) state_d = bise_pkg::B_CCHK;
              else state_d = bise_pkg::B_RESP;
            end
            default: state_d = bise_pkg::B_RESP;
          endcase
        end
      end
      bise_pkg::B_CLEAR: if (sweep_last) state_d = bise_pkg::B_IDLE;
      bise_pkg::B_ELEM: begin
        state_d = bise_pkg::B_IDLE;
        unique case (op_q)
          bise_pkg::OP_UNION: if (!m_rdata) state_d = bise_pkg::B_RESP;
          bise_pkg::OP_INTER: begin
            if (cmd_q.kind == bise_pkg::CMD_RIGHT && m_rdata) state_d = bise_pkg::B_RESP;
          end
          bise_pkg::OP_DIFF: begin
            if (cmd_q.kind == bise_pkg::CMD_LEFT && !m_rdata && list_full)
              state_d = bise_pkg::B_RESP;
          end
          default: state_d = bise_pkg::B_IDLE;
        endcase
      end
      bise_pkg::B_DLIST: state_d = bise_pkg::B_DMARK;
      bise_pkg::B_DMARK: begin
        if (m_rdata || !diff_more) state_d = bise_pkg::B_RESP;
        else state_d = bise_pkg::B_DLIST;
      end
      bise_pkg::B_CCHK: begin
        if (!m_rdata || !comp_more) state_d = bise_pkg::B_RESP;
      end
      bise_pkg::B_RESP: if (slot_free) state_d = bise_pkg::B_IDLE;
      default: state_d = bise_pkg::B_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d      = op_q;
    cmd_d     = cmd_q;
    res_st_d  = res_st_q;
    res_idx_d = res_idx_q;
    lv_d      = lv_q;
    sw_d      = sw_q;
    lc_d      = lc_q;
    wp_d      = wp_q;
    init_d    = init_q;
    ov_d      = ov_q && out_stall_i;
    oi_d      = oi_q;
    os_d      = os_q;
    pop_o     = 1'b0;
    m_we      = 1'b0;
    m_waddr   = sw_q;
    m_wdata   = 1'b0;
    m_raddr   = AW'(head_i.idx);
    l_we      = 1'b0;
    l_waddr   = LAW'(lc_q);
    l_wdata   = cmd_q.idx;
    l_raddr   = LAW'(wp_q);
    unique case (state_q)
      bise_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          cmd_d     = head_i;
          res_idx_d = '0;
          res_st_d  = bise_pkg::ST_END;
          unique case (head_i.kind)
            bise_pkg::CMD_BEGIN: begin
              op_d = head_i.op;
              lc_d = '0;
              wp_d = '0;
              sw_d = '0;
            end
            bise_pkg::CMD_FINISH: begin
              wp_d = '0;
              sw_d = '0;
            end
            bise_pkg::CMD_LEFT, bise_pkg::CMD_RIGHT: m_raddr = AW'(head_i.idx);
            bise_pkg::CMD_PULL: begin
              if (op_q == bise_pkg::OP_DIFF && diff_more) begin
                wp_d = wp_q + WPW'(1);
              end else if (op_q == bise_pkg::OP_COMPL && comp_more) begin
                m_raddr = AW'(wp_q);
                lv_d    = AW'(wp_q);
                wp_d    = wp_q + WPW'(1);
              end
            end
            default: res_st_d = bise_pkg::ST_ERR;
          endcase
        end
      end
      bise_pkg::B_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = sw_q;
        sw_d    = sw_q + AW'(1);
        if (sweep_last) init_d = 1'b0;
      end
      bise_pkg::B_ELEM: begin
        m_waddr   = AW'(cmd_q.idx);
        res_idx_d = AW'(cmd_q.idx);
        res_st_d  = bise_pkg::ST_ELEM;
        unique case (op_q)
          bise_pkg::OP_UNION: begin
            m_we    = !m_rdata;
            m_wdata = 1'b1;
          end
          bise_pkg::OP_INTER: begin
            m_we    = (cmd_q.kind == bise_pkg::CMD_LEFT) || m_rdata;
            m_wdata = (cmd_q.kind == bise_pkg::CMD_LEFT);
          end
          bise_pkg::OP_DIFF: begin
            if (cmd_q.kind == bise_pkg::CMD_LEFT) begin
              if (!m_rdata && list_full) begin
                res_idx_d = '0;
                res_st_d  = bise_pkg::ST_ERR;
              end else begin
                m_we    = 1'b1;
                m_wdata = 1'b1;
                if (!m_rdata) begin
                  l_we = 1'b1;
                  lc_d = lc_q + LCW'(1);
                end
              end
            end else begin
              m_we    = 1'b1;
              m_wdata = 1'b0;
            end
          end
          default: begin
            m_we    = 1'b1;
            m_wdata = 1'b1;
          end
        endcase
      end
      bise_pkg::B_DLIST: begin
        lv_d    = AW'(l_rdata);
        m_raddr = AW'(l_rdata);
      end
      bise_pkg::B_DMARK: begin
        m_waddr = lv_q;
        if (m_rdata) begin
          m_we      = 1'b1;
          res_idx_d = lv_q;
          res_st_d  = bise_pkg::ST_ELEM;
        end else if (diff_more) begin
          wp_d = wp_q + WPW'(1);
        end else begin
          res_idx_d = '0;
          res_st_d  = bise_pkg::ST_END;
        end
      end
      bise_pkg::B_CCHK: begin
        m_we    = 1'b1;
        m_waddr = lv_q;
        if (!m_rdata) begin
          res_idx_d = lv_q;
          res_st_d  = bise_pkg::ST_ELEM;
        end else if (comp_more) begin
          m_raddr = AW'(wp_q);
          lv_d    = AW'(wp_q);
          wp_d    = wp_q + WPW'(1);
        end else begin
          res_idx_d = '0;
          res_st_d  = bise_pkg::ST_END;
        end
      end
      bise_pkg::B_RESP: begin
        if (slot_free) begin
          ov_d = 1'b1;
          oi_d = bise_pkg::IDX_W'(res_idx_q);
          os_d = res_st_q;
        end
      end
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    res_st_q  <= res_st_d;
    res_idx_q <= res_idx_d;
    lv_q      <= lv_d;
    oi_q      <= oi_d;
    os_q      <= os_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bise_pkg::B_CLEAR;
      op_q    <= bise_pkg::OP_UNION;
      sw_q    <= '0;
      lc_q    <= '0;
      wp_q    <= '0;
      init_q  <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      sw_q    <= sw_d;
      lc_q    <= lc_d;
      wp_q    <= wp_d;
      init_q  <= init_d;
      ov_q    <= ov_d;
    end
  end

endmodule

[design/bitmap_index_set_engine_top.sv]
// Element beat: pop with bitmap read, then read-modify-write, then result register
// (the result register step only when the beat yields a result).
// Begin, and finish under union or intersection: a bitmap sweep clears every entry.
// Pull: difference walks stored entries (list read, then mark check); complement checks each index in turn.
// Up to 2 beats queue between classifier and executor; one beat at a time executes.
// Reset is asynchronous, active low; then a sweep over all MAX_ITEMS entries clears the bitmap.
module bitmap_index_set_engine_top #(
  parameter int MAX_ITEMS  = bise_pkg::MAX_ITEMS_DEF,
  parameter int LIST_DEPTH = bise_pkg::LIST_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bise_pkg::CNT_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 req_type_i,
  input  logic [1:0]                 set_op_i,
  input  logic [bise_pkg::IDX_W-1:0] item_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bise_pkg::IDX_W-1:0] out_index_o,
  output logic [1:0]                 status_o
);

  localparam int UW = $clog2(MAX_ITEMS + 1);

  logic [bise_pkg::CNT_W-1:0] item_count_q;
  logic [UW-1:0]              univ;
  logic                       accept, pop, empty, full, init;
  bise_pkg::cmd_t             cmd, head;

  assign cfg_ready_o = 1'b1;
  assign univ = (32'(item_count_q) > 32'(MAX_ITEMS)) ? UW'(MAX_ITEMS) : UW'(item_count_q);
  assign in_stall_o = full || init;
  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= bise_pkg::ITEM_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      item_count_q <= cfg_data_i;
    end
  end

  bise_front #(.UW(UW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .set_op_i     (set_op_i),
    .item_index_i (item_index_i),
    .univ_i       (univ),
    .cmd_o        (cmd)
  );

  bise_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (cmd),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  bise_back #(
    .MAX_ITEMS  (MAX_ITEMS),
    .LIST_DEPTH (LIST_DEPTH),
    .UW         (UW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .univ_i       (univ),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .init_o       (init),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_index_o  (out_index_o),
    .out_status_o (status_o)
  );

endmodule

[design/bise_checker.sv]
module bise_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] out_index_o,
  input logic [1:0]  status_o
);

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status code");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != 2'd0) |-> out_index_o == '0)
    else $error("nonzero index on end or error");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_index_o) && $stable(status_o)))
    else $error("stalled beat changed");

endmodule

bind bitmap_index_set_engine_top bise_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_index_o (out_index_o),
  .status_o    (status_o)
);

[bench/tb_bitmap_index_set_engine_top.sv]
`timescale 1ns / 1ps

module tb_bitmap_index_set_engine_top;

  typedef struct {
    logic [2:0]                 req;
    logic [1:0]                 op;
    logic [bise_pkg::IDX_W-1:0] idx;
  } beat_t;

  typedef struct {
    logic [bise_pkg::IDX_W-1:0] idx;
    logic [1:0]                 st;
  } result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [bise_pkg::CNT_W-1:0] cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [2:0]                 req_type_i;
  logic [1:0]                 set_op_i;
  logic [bise_pkg::IDX_W-1:0] item_index_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [bise_pkg::IDX_W-1:0] out_index_o;
  logic [1:0]                 status_o;

  bitmap_index_set_engine_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .set_op_i    (set_op_i),
    .item_index_i(item_index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_index_o (out_index_o),
    .status_o    (status_o)
  );

  beat_t   pending_q[$];
  result_t expected_q[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles = 0;
  bit      hold_go = 1'b0;

  // shadow of the engine state
  bit                         marks[bise_pkg::MAX_ITEMS_DEF];
  logic [bise_pkg::IDX_W-1:0] left_store[bise_pkg::LIST_DEPTH_DEF];
  int                         left_cnt;
  int                         walk_ptr;
  bise_pkg::op_e              cur_op;
  bise_pkg::phase_e           cur_phase;
  int                         item_count;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int universe_size();
    return (item_count > bise_pkg::MAX_ITEMS_DEF) ? bise_pkg::MAX_ITEMS_DEF : item_count;
  endfunction

  function automatic void clear_marks();
    foreach (marks[i]) marks[i] = 1'b0;
  endfunction

  function automatic void push_result(int idx, logic [1:0] st);
    result_t r;
    r.idx = idx[bise_pkg::IDX_W-1:0];
    r.st  = st;
    expected_q.push_back(r);
  endfunction

  function automatic void walk_next();
    int v;
    if (cur_op == bise_pkg::OP_DIFF) begin
      while (walk_ptr < left_cnt) begin
        v = left_store[walk_ptr];
        walk_ptr++;
        if (marks[v]) begin
          marks[v] = 1'b0;
          push_result(v, bise_pkg::ST_ELEM);
          return;
        end
      end
    end else if (cur_op == bise_pkg::OP_COMPL) begin
      while (walk_ptr < universe_size()) begin
        v = walk_ptr;
        walk_ptr++;
        if (!marks[v]) begin
          push_result(v, bise_pkg::ST_ELEM);
          return;
        end
        marks[v] = 1'b0;
      end
    end
    push_result(0, bise_pkg::ST_END);
  endfunction

  function automatic void predict_set_op(beat_t b);
    int  idx;
    bit  is_left;
    idx = b.idx;
    is_left = (b.req == bise_pkg::REQ_LEFT);
    case (b.req)
      bise_pkg::REQ_BEGIN: begin
        if (cur_phase == bise_pkg::PH_LEFT || cur_phase == bise_pkg::PH_RIGHT) begin
          push_result(0, bise_pkg::ST_ERR);
        end else begin
          clear_marks();
          left_cnt = 0;
          walk_ptr = 0;
          cur_op = bise_pkg::op_e'(b.op);
          cur_phase = bise_pkg::PH_LEFT;
        end
      end
      bise_pkg::REQ_LEFT, bise_pkg::REQ_RIGHT: begin
        if ((is_left && cur_phase != bise_pkg::PH_LEFT) ||
            (!is_left && cur_phase != bise_pkg::PH_LEFT && cur_phase != bise_pkg::PH_RIGHT) ||
            (is_left && cur_op == bise_pkg::OP_COMPL) || idx >= universe_size()) begin
          push_result(0, bise_pkg::ST_ERR);
          return;
        end
        if (cur_op == bise_pkg::OP_DIFF && is_left && !marks[idx]) begin
          if (left_cnt >= bise_pkg::LIST_DEPTH_DEF) begin
            push_result(0, bise_pkg::ST_ERR);
            return;
          end
          left_store[left_cnt] = b.idx;
          left_cnt++;
        end
        if (!is_left) cur_phase = bise_pkg::PH_RIGHT;
        case (cur_op)
          bise_pkg::OP_UNION: begin
            if (!marks[idx]) begin
              marks[idx] = 1'b1;
              push_result(idx, bise_pkg::ST_ELEM);
            end
          end
          bise_pkg::OP_INTER: begin
            if (is_left) begin
              marks[idx] = 1'b1;
            end else if (marks[idx]) begin
              marks[idx] = 1'b0;
              push_result(idx, bise_pkg::ST_ELEM);
            end
          end
          bise_pkg::OP_DIFF: marks[idx] = is_left;
          default: marks[idx] = 1'b1;
        endcase
      end
      bise_pkg::REQ_FINISH: begin
        if (cur_phase != bise_pkg::PH_LEFT && cur_phase != bise_pkg::PH_RIGHT) begin
          push_result(0, bise_pkg::ST_ERR);
        end else begin
          if (cur_op == bise_pkg::OP_UNION || cur_op == bise_pkg::OP_INTER) clear_marks();
          walk_ptr = 0;
          cur_phase = bise_pkg::PH_OUT;
        end
      end
      bise_pkg::REQ_PULL: begin
        if (cur_phase != bise_pkg::PH_OUT) push_result(0, bise_pkg::ST_ERR);
        else walk_next();
      end
      default: push_result(0, bise_pkg::ST_ERR);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t b;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= '0;
      set_op_i     <= '0;
      item_index_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        b.req = req_type_i;
        b.op  = set_op_i;
        b.idx = item_index_i;
        predict_set_op(b);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          b = pending_q.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= b.req;
          set_op_i     <= b.op;
          item_index_i <= b.idx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat, status", status_o, -1);
        end else begin
          e = expected_q.pop_front();
          if (status_o !== e.st) report_mismatch("status", status_o, e.st);
          if (out_index_o !== e.idx) report_mismatch("out_index", out_index_o, e.idx);
        end
      end
      out_stall_i <= (hold_cycles > 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_go) hold_cycles <= 2 * bise_pkg::MAX_ITEMS_DEF + 400;
    else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic add_beat(int req, int op, int idx);
    beat_t b;
    b.req = req[2:0];
    b.op  = op[1:0];
    b.idx = idx[bise_pkg::IDX_W-1:0];
    pending_q.push_back(b);
  endtask

  function automatic int pick_index();
    int n;
    n = universe_size();
    if (n == 0 || $urandom_range(0, 99) < 15)
      return $urandom_range(0, (1 << bise_pkg::IDX_W) - 1);
    return $urandom_range(0, n - 1);
  endfunction

  // one operation: begin, left run, right run, finish, pulls; some noise
  task automatic add_operation(output int n);
    bise_pkg::op_e op;
    int  nl, nr, np;
    op = bise_pkg::op_e'($urandom_range(0, 3));
    n = 0;
    add_beat(bise_pkg::REQ_BEGIN, op, $urandom);
    nl = $urandom_range(0, 7);
    nr = $urandom_range(0, 7);
    np = $urandom_range(1, 8);
    repeat (nl) add_beat(bise_pkg::REQ_LEFT, $urandom, pick_index());
    repeat (nr) add_beat(bise_pkg::REQ_RIGHT, $urandom, pick_index());
    if ($urandom_range(0, 99) < 20) begin
      add_beat($urandom_range(0, 7), $urandom, $urandom);
      n++;
    end
    add_beat(bise_pkg::REQ_FINISH, $urandom, $urandom);
    repeat (np) add_beat(bise_pkg::REQ_PULL, $urandom, $urandom);
    n += 2 + nl + nr + np;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (2 * bise_pkg::MAX_ITEMS_DEF + 200) @(posedge clk_i);
  endtask

  task automatic write_count(int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[bise_pkg::CNT_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    item_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int items);
    int n;
    while (items > 0) begin
      add_operation(n);
      items -= n;
      while (pending_q.size() > 8) @(posedge clk_i);
    end
    drain();
  endtask

  initial begin
    clear_marks();
    left_cnt = 0;
    walk_ptr = 0;
    cur_op = bise_pkg::OP_UNION;
    cur_phase = bise_pkg::PH_IDLE;
    item_count = int'(bise_pkg::ITEM_COUNT_RST);
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b0;
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    add_beat(bise_pkg::REQ_PULL, bise_pkg::OP_UNION, 0);
    add_beat(bise_pkg::REQ_BEGIN, bise_pkg::OP_UNION, 0);
    add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_UNION, 0);
    add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_UNION, 4095);
    add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_UNION, 0);
    add_beat(bise_pkg::REQ_BEGIN, bise_pkg::OP_INTER, 0);
    add_beat(bise_pkg::REQ_RIGHT, bise_pkg::OP_UNION, 4095);
    add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_UNION, 5);
    add_beat(bise_pkg::REQ_FINISH, bise_pkg::OP_UNION, 0);
    add_beat(bise_pkg::REQ_PULL, bise_pkg::OP_UNION, 0);
    add_beat(bise_pkg::REQ_FINISH, bise_pkg::OP_UNION, 0);
    add_beat(bise_pkg::REQ_BEGIN, bise_pkg::OP_INTER, 0);
    add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_INTER, 3);
    add_beat(bise_pkg::REQ_RIGHT, bise_pkg::OP_INTER, 3);
    add_beat(bise_pkg::REQ_RIGHT, bise_pkg::OP_INTER, 9);
    add_beat(bise_pkg::REQ_FINISH, bise_pkg::OP_INTER, 0);
    add_beat(bise_pkg::REQ_BEGIN, bise_pkg::OP_DIFF, 0);
    add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_DIFF, 7);
    add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_DIFF, 2);
    add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_DIFF, 7);
    add_beat(bise_pkg::REQ_RIGHT, bise_pkg::OP_DIFF, 2);
    add_beat(bise_pkg::REQ_FINISH, bise_pkg::OP_DIFF, 0);
    repeat (3) add_beat(bise_pkg::REQ_PULL, bise_pkg::OP_DIFF, 0);
    add_beat(bise_pkg::REQ_BEGIN, bise_pkg::OP_COMPL, 0);
    add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_COMPL, 1);
    add_beat(3'd5, bise_pkg::OP_COMPL, 0);
    add_beat(3'd7, 2'd3, 4095);
    drain();

    write_count(5);
    add_beat(bise_pkg::REQ_RIGHT, bise_pkg::OP_COMPL, 1);
    add_beat(bise_pkg::REQ_RIGHT, bise_pkg::OP_COMPL, 5);
    add_beat(bise_pkg::REQ_FINISH, bise_pkg::OP_COMPL, 0);
    repeat (6) add_beat(bise_pkg::REQ_PULL, bise_pkg::OP_COMPL, 0);
    run_random(100);

    write_count(1);
    send_idle_pct = 57;
    run_random(60);

    write_count(0);
    run_random(15);

    write_count(37);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    run_random(90);

    // long receiver hold-off while union results pile up
    write_count(8191);
    recv_stall_pct = 0;
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    add_beat(bise_pkg::REQ_BEGIN, bise_pkg::OP_UNION, 0);
    for (int i = 0; i < 24; i++) add_beat(bise_pkg::REQ_LEFT, bise_pkg::OP_UNION, $urandom);
    add_beat(bise_pkg::REQ_FINISH, bise_pkg::OP_UNION, 0);
    drain();

    write_count(12);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    run_random(90);

    write_count(4096);
    run_random(40);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/bise_pkg.sv
design/bise_ram.sv
design/bise_front.sv
design/bise_fifo.sv
design/bise_back.sv
design/bitmap_index_set_engine_top.sv
design/bise_checker.sv
bench/tb_bitmap_index_set_engine_top.sv
